### hw/rtl/nirs_pkg.sv
// Shared widths, register indexes, reset values and types for the Newton
// inverse-square-root block. No dependencies.
package nirs_pkg;

	// Item and register field widths
	localparam int X_W     = 24;  // value, Q2.22
	localparam int G_W     = 32;  // guess, Q12.20
	localparam int LIM_W   = 32;  // error limit, Q0.32
	localparam int STEPS_W = 7;
	localparam int E_W     = 58;  // x*g*g, Q26.32
	localparam int G_FRAC  = 20;

	localparam int MAX_ITERATIONS_DEF = 64;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_GUESS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT   = 1'b1;

	localparam logic [G_W-1:0]   INITIAL_GUESS_RST = 32'd1048576;
	localparam logic [LIM_W-1:0] ERROR_LIMIT_RST   = 32'd42950;

	// Cell-row multiplier geometry: A is split across the cells, B is fed
	// one digit per cycle
	localparam int DIGIT_W    = 16;
	localparam int NUM_CELLS  = 4;
	localparam int B_DIGITS   = 2;
	localparam int A_W        = DIGIT_W * NUM_CELLS;
	localparam int B_W        = DIGIT_W * B_DIGITS;
	localparam int PROD_W     = A_W + B_W;
	localparam int MUL_CYCLES = NUM_CELLS + B_DIGITS;
	localparam int MUL_CNT_W  = $clog2(MUL_CYCLES + 1);

	typedef struct packed {
		logic clear;  // zero the partial sums
		logic shift;  // accumulate one digit and move down one cell
	} cell_ctrl_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SQR  = 5'b00010,
		ST_XMUL = 5'b00100,
		ST_CUBE = 5'b01000,
		ST_ROOT = 5'b10000
	} nirs_state_t;

endpackage

### hw/rtl/nirs_cell.sv
// One cell of the multiplier row: a digit of A times the current B digit,
// plus a carry-save partial sum. Depends on nirs_pkg.
module nirs_cell (
	input  logic                         clk,
	input  nirs_pkg::cell_ctrl_t         ctrl,
	input  logic [nirs_pkg::DIGIT_W-1:0] a_digit,
	input  logic [nirs_pkg::DIGIT_W-1:0] b_digit,
	input  logic [nirs_pkg::DIGIT_W-1:0] sum_in,   // from upper neighbor
	output logic [nirs_pkg::DIGIT_W-1:0] sum_out   // to lower neighbor
);
	import nirs_pkg::*;

	logic [DIGIT_W-1:0]   sum_q;
	logic [DIGIT_W-1:0]   carry_q;
	logic [2*DIGIT_W-1:0] acc;

	// Bounded below 2^32: carry never exceeds one digit.
	assign acc = ({{DIGIT_W{1'b0}}, a_digit} * {{DIGIT_W{1'b0}}, b_digit})
		+ {{DIGIT_W{1'b0}}, sum_q} + {{DIGIT_W{1'b0}}, carry_q};

	assign sum_out = acc[DIGIT_W-1:0];

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			sum_q   <= '0;
			carry_q <= '0;
		end else if (ctrl.shift) begin
			sum_q   <= sum_in;
			carry_q <= acc[2*DIGIT_W-1:DIGIT_W];
		end
	end

endmodule

### hw/rtl/nirs_mul.sv
// Row-of-cells multiplier: A held across NUM_CELLS cells, B fed one digit a
// cycle, product digits leave the bottom cell. Depends on nirs_pkg, nirs_cell.
module nirs_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [nirs_pkg::A_W-1:0]    a,
	input  logic [nirs_pkg::B_W-1:0]    b,
	output logic                        done,
	output logic [nirs_pkg::PROD_W-1:0] prod
);
	import nirs_pkg::*;

	logic [A_W-1:0]       a_q;
	logic [B_W-1:0]       b_q;
	logic [PROD_W-1:0]    prod_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 done_q;
	cell_ctrl_t           ctrl;
	logic [DIGIT_W-1:0]   link [NUM_CELLS+1];

	assign ctrl.clear = start;
	assign ctrl.shift = (cnt_q != '0) && !start;

	// top of the row shifts in zeros
	assign link[NUM_CELLS] = '0;

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		nirs_cell u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.a_digit (a_q[i*DIGIT_W +: DIGIT_W]),
			.b_digit (b_q[DIGIT_W-1:0]),
			.sum_in  (link[i+1]),
			.sum_out (link[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= MUL_CNT_W'(MUL_CYCLES);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == MUL_CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (ctrl.shift) begin
			b_q    <= b_q >> DIGIT_W;
			prod_q <= {link[0], prod_q[PROD_W-1:DIGIT_W]};
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

### hw/rtl/newton_inverse_sqrt_root.sv
// Top level: Newton-Raphson inverse square root sequencer around the
// cell-row multiplier, giving sqrt(x) = x*g. Depends on nirs_pkg, nirs_mul.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------
//  item in   | start, busy            | value[23:0], last_value
//  result    | done (1-cycle strobe)  | square_root[23:0], converged,
//            |                        | steps_taken[6:0], last_result
//  config    | cfg_write              | cfg_index[0], cfg_data[31:0]
//
//  An item is taken when start is high and busy is low; one item at a time.
//  Every multiply runs through the 4-cell row, and each Newton step needs
//  three of them (g*g, *x, *g), up to the 64-step default cap.
//  done is high for one cycle; busy is already low then, so the next item
//  can be taken in that same cycle. The receiver cannot hold results off.
//  Reset (arst_n low) returns to idle and reloads both config registers.
module newton_inverse_sqrt_root #(
	parameter int MAX_ITERATIONS = nirs_pkg::MAX_ITERATIONS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// item in
	input  logic                           start,
	output logic                           busy,
	input  logic [nirs_pkg::X_W-1:0]       value,
	input  logic                           last_value,
	// result
	output logic                           done,
	output logic [nirs_pkg::X_W-1:0]       square_root,
	output logic                           converged,
	output logic [nirs_pkg::STEPS_W-1:0]   steps_taken,
	output logic                           last_result,
	// configuration
	input  logic                           cfg_write,
	input  logic [nirs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nirs_pkg::G_W-1:0]       cfg_data
);
	import nirs_pkg::*;

	localparam logic [STEPS_W-1:0] STEP_CAP = STEPS_W'(MAX_ITERATIONS);
	localparam logic [E_W-1:0]      ONE_Q32  = E_W'(64'h1_0000_0000);
	localparam int                  ROOT_LO  = G_FRAC;
	localparam int                  ROOT_HI  = X_W + G_W - 1;

	// Config registers
	logic [G_W-1:0]   initial_guess_q;
	logic [LIM_W-1:0] error_limit_q;

	// Per-item working state
	nirs_state_t        state_q, state_d;
	logic [G_W-1:0]     g_q;
	logic [X_W-1:0]     x_q;
	logic               last_q;
	logic [STEPS_W-1:0] steps_q;
	logic               conv_q;

	// Result registers
	logic               done_q;
	logic [X_W-1:0]     root_q;
	logic               conv_out_q;
	logic [STEPS_W-1:0] steps_out_q;
	logic               last_out_q;

	// Multiplier hookup
	logic              mul_start;
	logic [A_W-1:0]    mul_a;
	logic [B_W-1:0]    mul_b;
	logic              mul_done;
	logic [PROD_W-1:0] mul_prod;

	// Datapath around the product
	logic [E_W-1:0]   e_val;     // x*g*g, Q26.32
	logic [E_W-1:0]   err;
	logic             need_step;
	logic [E_W-1:0]   cube;      // x*g^3, Q38.20
	logic [G_W+1:0]   three_g;
	logic [G_W+1:0]   diff;
	logic [G_W:0]     half;
	logic [G_W-1:0]   next_g;
	logic [X_W-1:0]   root_sat;
	logic             may_step;

	nirs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_guess_q <= INITIAL_GUESS_RST;
			error_limit_q   <= ERROR_LIMIT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_INITIAL_GUESS: initial_guess_q <= cfg_data;
				CFG_ERROR_LIMIT:   error_limit_q   <= cfg_data;
			endcase
		end
	end

	// Error test on x*g*g (valid when the *x multiply finishes)
	assign e_val     = mul_prod[E_W+29:30];
	assign err       = (e_val >= ONE_Q32) ? (e_val - ONE_Q32) : (ONE_Q32 - e_val);
	assign need_step = err > E_W'(error_limit_q);
	assign may_step  = need_step && (steps_q < STEP_CAP);

	// Newton update g' = (3g - x*g^3)/2, clamped at 0 and at all-ones
	assign cube    = mul_prod[E_W+31:32];
	assign three_g = {2'b00, g_q} + {1'b0, g_q, 1'b0};
	assign diff    = three_g - cube[G_W+1:0];
	assign half    = diff[G_W+1:1];
	always_comb begin
		if (cube >= E_W'(three_g))
			next_g = '0;
		else if (half[G_W])
			next_g = '1;
		else
			next_g = half[G_W-1:0];
	end

	// x*g back to Q2.22, saturated
	assign root_sat = (|mul_prod[ROOT_HI:ROOT_LO+X_W]) ? '1 : mul_prod[ROOT_LO+X_W-1:ROOT_LO];

	// Sequencer: busy states wait for a multiply, then launch the next or idle
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		mul_a     = A_W'(g_q);
		mul_b     = B_W'(x_q);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					mul_start = 1'b1;
					mul_a     = A_W'(initial_guess_q);
					mul_b     = B_W'(initial_guess_q);
					state_d   = ST_SQR;
				end
			end
			ST_SQR: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = mul_prod[A_W-1:0];
					mul_b     = B_W'(x_q);
					state_d   = ST_XMUL;
				end
			end
			ST_XMUL: begin
				if (mul_done) begin
					mul_start = 1'b1;
					if (may_step) begin
						mul_a   = A_W'(e_val);
						mul_b   = B_W'(g_q);
						state_d = ST_CUBE;
					end else begin
						mul_a   = A_W'(g_q);
						mul_b   = B_W'(x_q);
						state_d = ST_ROOT;
					end
				end
			end
			ST_CUBE: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = A_W'(next_g);
					mul_b     = B_W'(next_g);
					state_d   = ST_SQR;
				end
			end
			ST_ROOT: begin
				if (mul_done)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_ROOT) && mul_done;
		end
	end

	// Working payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			g_q     <= initial_guess_q;
			x_q     <= value;
			last_q  <= last_value;
			steps_q <= '0;
		end
		if (state_q == ST_XMUL && mul_done)
			conv_q <= !need_step;
		if (state_q == ST_CUBE && mul_done) begin
			g_q     <= next_g;
			steps_q <= steps_q + 1'b1;
		end
		if (state_q == ST_ROOT && mul_done) begin
			root_q      <= root_sat;
			conv_out_q  <= conv_q;
			steps_out_q <= steps_q;
			last_out_q  <= last_q;
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign square_root = root_q;
	assign converged   = conv_out_q;
	assign steps_taken = steps_out_q;
	assign last_result = last_out_q;

endmodule

### hw/rtl/nirs_checker.sv
// Port-level checks for newton_inverse_sqrt_root, bound to the top level.
// Depends on nirs_pkg and the top level's ports.
module nirs_checker #(
	parameter int MAX_ITERATIONS = nirs_pkg::MAX_ITERATIONS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic                         converged,
	input logic [nirs_pkg::STEPS_W-1:0] steps_taken
);
	import nirs_pkg::*;

	localparam logic [STEPS_W-1:0] STEP_CAP = STEPS_W'(MAX_ITERATIONS);

	// a taken item keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item taken but block not busy");

	// a result only ends a busy stretch
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("result strobe outside end of item");

	// non-converged means the step cap was hit
	a_cap_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		done && !converged |-> steps_taken == STEP_CAP)
		else $error("not converged below step cap");

	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> steps_taken <= STEP_CAP)
		else $error("step count above cap");

endmodule

bind newton_inverse_sqrt_root nirs_checker #(
	.MAX_ITERATIONS (MAX_ITERATIONS)
) u_nirs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.converged   (converged),
	.steps_taken (steps_taken)
);
